[rtl/ssched_pkg.sv]
package ssched_pkg;

    // command codes carried by each transaction
    typedef enum logic [2:0] {
        OP_TICK           = 3'd0,
        OP_HEARTBEAT      = 3'd1,
        OP_PANIC          = 3'd2,
        OP_CLEAR_PANIC    = 3'd3,
        OP_CLEAR_FAILSAFE = 3'd4,
        OP_SET_BREATH     = 3'd5,
        OP_EXT_FAILSAFE   = 3'd6,
        OP_START          = 3'd7
    } opcode_t;

    // configuration register indexes
    localparam logic [1:0] REG_HB_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_TASK_PERIOD = 2'd1;
    localparam logic [1:0] REG_BREATH_THR  = 2'd2;

    // configuration reset values
    localparam logic [30:0] HB_TIMEOUT_RST  = 31'd5000;
    localparam logic [15:0] TASK_PERIOD_RST = 16'd100;
    localparam logic [15:0] BREATH_THR_RST  = 16'd100;

    // failsafe causes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_HB     = 2'd1;
    localparam logic [1:0] CAUSE_BREATH = 2'd2;
    localparam logic [1:0] CAUSE_OTHER  = 2'd3;

    // safety actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_PANIC    = 2'd1;
    localparam logic [1:0] ACT_FAILSAFE = 2'd2;
    localparam logic [1:0] ACT_OFF      = 2'd3;

    // pid task choice
    localparam logic [1:0] TASK_NONE     = 2'd0;
    localparam logic [1:0] TASK_AUTOTUNE = 2'd1;
    localparam logic [1:0] TASK_EQUIL    = 2'd2;
    localparam logic [1:0] TASK_CONTROL  = 2'd3;

    // event codes
    localparam logic [2:0] EVT_NONE         = 3'd0;
    localparam logic [2:0] EVT_FS_TRIGGERED = 3'd1;
    localparam logic [2:0] EVT_BREATH_CLR   = 3'd2;
    localparam logic [2:0] EVT_PANIC        = 3'd3;
    localparam logic [2:0] EVT_HB_RECOVERED = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
        logic [15:0] breath_rate;
        logic        autotune_on;
        logic        equilibrium_on;
        logic        control_on;
        logic        flag_value;
        logic [1:0]  failsafe_cause_in;
    } item_t;

    typedef struct packed {
        logic       failsafe_active;
        logic [1:0] failsafe_cause;
        logic       panic_active;
        logic [1:0] safety_action;
        logic       run_periodic;
        logic [1:0] pid_task;
        logic [2:0] event_code;
    } result_t;

    typedef struct packed {
        logic [30:0] hb_timeout;
        logic [15:0] task_period;
        logic [15:0] breath_thr;
    } cfg_t;

endpackage

[rtl/safety_supervisor_scheduler.sv]
// a transaction is captured in the input register, stepped by the supervisor core and
// captured in the result register, which drives the outputs
// throughput: one transaction per cycle while out_stall is low, set by the state update
// in the supervisor core between the input register and the result register
// reset: asynchronous, active low; clears both stages, the supervisor latches
// and time stamps, enables the breath check and loads the register defaults
module safety_supervisor_scheduler
    import ssched_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic [15:0] breath_rate,
    input  logic        autotune_on,
    input  logic        equilibrium_on,
    input  logic        control_on,
    input  logic        flag_value,
    input  logic [1:0]  failsafe_cause_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        failsafe_active,
    output logic [1:0]  failsafe_cause,
    output logic        panic_active,
    output logic [1:0]  safety_action,
    output logic        run_periodic,
    output logic [1:0]  pid_task,
    output logic [2:0]  event_code
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res_reg;
    result_t step_res;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    step_en;
    logic    in_take;

    ssched_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pack the incoming transaction
    always_comb
    begin
        in_item.opcode            = opcode;
        in_item.now_ms            = now_ms;
        in_item.breath_rate       = breath_rate;
        in_item.autotune_on       = autotune_on;
        in_item.equilibrium_on    = equilibrium_on;
        in_item.control_on        = control_on;
        in_item.flag_value        = flag_value;
        in_item.failsafe_cause_in = failsafe_cause_in;
    end

    // flow control across the two stages
    assign advance  = !res_valid_reg || !out_stall;
    assign step_en  = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign item_valid_next = in_take || (item_valid_reg && !advance);
    assign res_valid_next  = step_en || (res_valid_reg && out_stall);

    ssched_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(step_en),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_res)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_item;
        if (step_en)
            res_reg <= step_res;
    end

    assign out_valid       = res_valid_reg;
    assign failsafe_active = res_reg.failsafe_active;
    assign failsafe_cause  = res_reg.failsafe_cause;
    assign panic_active    = res_reg.panic_active;
    assign safety_action   = res_reg.safety_action;
    assign run_periodic    = res_reg.run_periodic;
    assign pid_task        = res_reg.pid_task;
    assign event_code      = res_reg.event_code;

endmodule

[rtl/ssched_cfg.sv]
module ssched_cfg
    import ssched_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode register writes, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HB_TIMEOUT:  cfg_next.hb_timeout  = cfg_data;
                REG_TASK_PERIOD: cfg_next.task_period = cfg_data[15:0];
                REG_BREATH_THR:  cfg_next.breath_thr  = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hb_timeout  <= HB_TIMEOUT_RST;
            cfg_reg.task_period <= TASK_PERIOD_RST;
            cfg_reg.breath_thr  <= BREATH_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ssched_core.sv]
module ssched_core
    import ssched_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic        fs_on_reg,    fs_on_next;
    logic [1:0]  fs_why_reg,   fs_why_next;
    logic        panic_reg,    panic_next;
    logic        breath_reg,   breath_next;
    logic [31:0] last_hb_reg,  last_hb_next;
    logic [31:0] last_task_reg, last_task_next;

    logic [31:0] hb_elapsed;
    logic [31:0] task_elapsed;
    logic [1:0]  act;
    logic [2:0]  evt;
    logic        periodic;
    logic [1:0]  task_sel;

    assign hb_elapsed   = item.now_ms - last_hb_reg;
    assign task_elapsed = item.now_ms - last_task_reg;

    // one command step against the supervisor state
    always_comb
    begin
        fs_on_next     = fs_on_reg;
        fs_why_next    = fs_why_reg;
        panic_next     = panic_reg;
        breath_next    = breath_reg;
        last_hb_next   = last_hb_reg;
        last_task_next = last_task_reg;
        act            = ACT_NONE;
        evt            = EVT_NONE;
        periodic       = 1'b0;
        task_sel       = TASK_NONE;

        case (opcode_t'(item.opcode))
            OP_TICK:
            begin
                // heartbeat watchdog
                if (hb_elapsed > {1'b0, cfg.hb_timeout} && !panic_reg && !fs_on_reg)
                begin
                    fs_on_next  = 1'b1;
                    fs_why_next = CAUSE_HB;
                    act         = ACT_FAILSAFE;
                    evt         = EVT_FS_TRIGGERED;
                end
                if (panic_reg)
                begin
                    act = ACT_PANIC;
                end
                else if (fs_on_next)
                begin
                    act = ACT_FAILSAFE;
                end
                else if (task_elapsed >= {16'd0, cfg.task_period})
                begin
                    // periodic tasks, latches are both clear here
                    periodic       = 1'b1;
                    last_task_next = item.now_ms;
                    if (breath_reg && item.breath_rate < cfg.breath_thr)
                    begin
                        fs_on_next  = 1'b1;
                        fs_why_next = CAUSE_BREATH;
                        act         = ACT_FAILSAFE;
                        evt         = EVT_FS_TRIGGERED;
                    end
                    if (item.autotune_on)
                        task_sel = TASK_AUTOTUNE;
                    else if (item.equilibrium_on)
                        task_sel = TASK_EQUIL;
                    else if (item.control_on)
                        task_sel = TASK_CONTROL;
                end
            end
            OP_HEARTBEAT:
            begin
                last_hb_next = item.now_ms;
                if (fs_on_reg && fs_why_reg == CAUSE_HB)
                begin
                    fs_on_next  = 1'b0;
                    fs_why_next = CAUSE_NONE;
                    evt         = EVT_HB_RECOVERED;
                end
            end
            OP_PANIC:
            begin
                if (!panic_reg)
                begin
                    panic_next  = 1'b1;
                    fs_on_next  = 1'b0;
                    fs_why_next = CAUSE_NONE;
                    act         = ACT_PANIC;
                    evt         = EVT_PANIC;
                end
            end
            OP_CLEAR_PANIC:
            begin
                panic_next = 1'b0;
                act        = ACT_OFF;
            end
            OP_CLEAR_FAILSAFE:
            begin
                fs_on_next  = 1'b0;
                fs_why_next = CAUSE_NONE;
            end
            OP_SET_BREATH:
            begin
                breath_next = item.flag_value;
                if (!item.flag_value && fs_on_reg && fs_why_reg == CAUSE_BREATH)
                begin
                    fs_on_next  = 1'b0;
                    fs_why_next = CAUSE_NONE;
                    evt         = EVT_BREATH_CLR;
                end
            end
            OP_EXT_FAILSAFE:
            begin
                if (!panic_reg && !fs_on_reg)
                begin
                    fs_on_next  = 1'b1;
                    fs_why_next = (item.failsafe_cause_in == CAUSE_NONE) ?
                                  CAUSE_OTHER : item.failsafe_cause_in;
                    act         = ACT_FAILSAFE;
                    evt         = EVT_FS_TRIGGERED;
                end
            end
            OP_START:
            begin
                fs_on_next     = 1'b0;
                fs_why_next    = CAUSE_NONE;
                last_hb_next   = item.now_ms;
                last_task_next = item.now_ms;
            end
            default:
            begin
                fs_on_next = fs_on_reg;
            end
        endcase
    end

    // supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_on_reg     <= 1'b0;
            fs_why_reg    <= CAUSE_NONE;
            panic_reg     <= 1'b0;
            breath_reg    <= 1'b1;
            last_hb_reg   <= 32'd0;
            last_task_reg <= 32'd0;
        end
        else if (step_en)
        begin
            fs_on_reg     <= fs_on_next;
            fs_why_reg    <= fs_why_next;
            panic_reg     <= panic_next;
            breath_reg    <= breath_next;
            last_hb_reg   <= last_hb_next;
            last_task_reg <= last_task_next;
        end
    end

    // result fields
    always_comb
    begin
        result.failsafe_active = fs_on_next;
        result.failsafe_cause  = fs_why_next;
        result.panic_active    = panic_next;
        result.safety_action   = act;
        result.run_periodic    = periodic;
        result.pid_task        = task_sel;
        result.event_code      = evt;
    end

endmodule
